// ===== hdl/sptt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the translator.
package sptt_pkg;

	localparam int NUM_FRAMES  = 1024;
	localparam int FRAME_WORDS = 512;
	localparam int FRAME_BITS  = 9;
	localparam int FIDX_W      = 10;
	localparam int MEM_AW      = 19;
	localparam int MEM_WORDS   = NUM_FRAMES * FRAME_WORDS;
	localparam int WORD_W      = 20;
	localparam int SEG_W       = 9;
	localparam int PAGE_W      = 10;
	localparam int VA_W        = 28;
	localparam int TAG_W       = 19;
	localparam int ZCNT_W      = 11;

	typedef enum logic [1:0] {
		K_READ      = 2'd0,
		K_WRITE     = 2'd1,
		K_LOAD_SEG  = 2'd2,
		K_LOAD_PAGE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_PF     = 3'd1,
		ST_ERR    = 3'd2,
		ST_OOF    = 3'd3,
		ST_LOADED = 3'd4
	} status_t;

	typedef struct packed {
		logic    clr_write;
		logic    take;
		logic    rd_seg;
		logic    seg_latch;
		logic    rd_page;
		logic    ent_latch;
		logic    hit_latch;
		logic    scan_init;
		logic    scan_pair;
		logic    scan_rd;
		logic    scan_next;
		logic    setup_alloc;
		logic    setup_load_seg;
		logic    setup_load_page;
		logic    zero_wr;
		logic    mark_wr;
		logic    entry_wr;
		logic    tlb_hit_upd;
		logic    tlb_fill;
		logic    res_load;
		status_t res_status;
		logic    res_hit;
	} cmd_t;

	typedef struct packed {
		logic  clr_done;
		kind_t kind;
		logic  tlb_hit;
		logic  tlb_en;
		logic  rd_m1;
		logic  rd_zero;
		logic  rd_le0;
		logic  rd_pos;
		logic  val_pos;
		logic  scan_found;
		logic  scan_last;
		logic  zero_last;
		logic  mark_last;
		logic  out_free;
	} sts_t;

endpackage

// ===== hdl/sptt_tlb.sv =====
// Translation buffer: tags, frames, LRU ranks and valid bits.
module sptt_tlb #(
	parameter int N = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [sptt_pkg::TAG_W-1:0] tag,
	input  logic                      upd_hit,
	input  logic                      fill,
	input  logic [sptt_pkg::FIDX_W-1:0] fill_frame,
	output logic                      hit,
	output logic [sptt_pkg::FIDX_W-1:0] hit_frame
);
	import sptt_pkg::*;

	localparam int IW = (N > 1) ? $clog2(N) : 1;

	logic [TAG_W-1:0]  tag_q   [N];
	logic [FIDX_W-1:0] frame_q [N];
	logic [IW-1:0]     rank_q  [N];
	logic [N-1:0]      valid_q;

	logic [IW-1:0] hidx;
	logic [IW-1:0] slot;
	logic [IW-1:0] floor_r;
	logic          inv_found;
	logic          rz_found;

	always_comb begin
		hit  = 1'b0;
		hidx = '0;
		for (int i = 0; i < N; i++) begin
			if (!hit && valid_q[i] && tag_q[i] == tag) begin
				hit  = 1'b1;
				hidx = IW'(i);
			end
		end
		hit_frame = frame_q[hidx];
	end

	// first free slot, else first rank-zero slot, else slot zero
	always_comb begin
		inv_found = 1'b0;
		rz_found  = 1'b0;
		slot      = '0;
		for (int i = 0; i < N; i++) begin
			if (!inv_found && !valid_q[i]) begin
				inv_found = 1'b1;
				slot      = IW'(i);
			end
		end
		if (!inv_found) begin
			for (int i = 0; i < N; i++) begin
				if (!rz_found && rank_q[i] == '0) begin
					rz_found = 1'b1;
					slot     = IW'(i);
				end
			end
		end
		floor_r = inv_found ? '0 : rank_q[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < N; i++) rank_q[i] <= '0;
		end else if (upd_hit) begin
			for (int j = 0; j < N; j++) begin
				if (IW'(j) != hidx && valid_q[j] && rank_q[j] > rank_q[hidx])
					rank_q[j] <= rank_q[j] - 1'b1;
			end
			rank_q[hidx] <= IW'(N - 1);
		end else if (fill) begin
			for (int j = 0; j < N; j++) begin
				if (IW'(j) != slot && valid_q[j] && rank_q[j] > floor_r)
					rank_q[j] <= rank_q[j] - 1'b1;
			end
			rank_q[slot]  <= IW'(N - 1);
			valid_q[slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fill && !upd_hit) begin
			tag_q[slot]   <= tag;
			frame_q[slot] <= fill_frame;
		end
	end

	// a fresh fill must hit on the same tag right after
	a_fill_hits: assert property (@(posedge clk) disable iff (!arst_n)
		fill && !upd_hit |=> hit)
		else $error("tlb fill did not produce a hit");

endmodule

// ===== hdl/sptt_dp.sv =====
// Datapath: word memory, frame bitmap, search, zeroing, buffer and result register.
module sptt_dp #(
	parameter int TLB_ENTRIES = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sptt_pkg::cmd_t               cmd,
	output sptt_pkg::sts_t               sts,
	input  logic [1:0]                   kind,
	input  logic [sptt_pkg::VA_W-1:0]    virt_addr,
	input  logic [sptt_pkg::SEG_W-1:0]   segment,
	input  logic [sptt_pkg::PAGE_W-1:0]  page,
	input  logic signed [sptt_pkg::WORD_W-1:0] entry_value,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	output logic                         tlb_hit,
	output logic [sptt_pkg::MEM_AW-1:0]  phys_addr
);
	import sptt_pkg::*;

	kind_t              kind_q;
	logic [VA_W-1:0]    va_q;
	logic [SEG_W-1:0]   seg_q;
	logic [PAGE_W-1:0]  pg_q;
	logic [WORD_W-1:0]  val_q;

	logic [WORD_W-1:0]  mem [MEM_WORDS];
	logic [WORD_W-1:0]  rdata_q;
	logic               bm [NUM_FRAMES];
	logic               bm_rdata_q;

	logic [MEM_AW-1:0]  clr_q;
	logic               tlb_en_q;
	logic [MEM_AW-1:0]  e_q;
	logic [MEM_AW-1:0]  ent_q;
	logic [FIDX_W-1:0]  scan_q;
	logic               prev_free_q;
	logic               pair_q;
	logic [MEM_AW-1:0]  zaddr_q;
	logic [ZCNT_W-1:0]  zleft_q;
	logic [FIDX_W:0]    mark_q;
	logic               mark_two_q;
	logic [MEM_AW-1:0]  eaddr_q;
	logic [WORD_W-1:0]  eval_q;
	logic               out_valid_q;
	status_t            status_q;
	logic               hit_q;
	logic [MEM_AW-1:0]  phys_q;

	logic [SEG_W-1:0]   s_f;
	logic [PAGE_W-1:0]  p_f;
	logic [FRAME_BITS-1:0] w_f;
	logic [MEM_AW-1:0]  seg_addr;
	logic [MEM_AW-1:0]  page_addr;
	logic [MEM_AW-1:0]  mem_raddr;
	logic               mem_we;
	logic [MEM_AW-1:0]  mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;
	logic               bm_we;
	logic [FIDX_W-1:0]  bm_waddr;
	logic               bm_wdata;
	logic               scan_free;
	logic [FIDX_W-1:0]  found_f;
	logic               t_hit;
	logic [FIDX_W-1:0]  t_frame;

	assign s_f = va_q[VA_W-1 -: SEG_W];
	assign p_f = va_q[FRAME_BITS +: PAGE_W];
	assign w_f = va_q[FRAME_BITS-1:0];

	assign seg_addr = (kind_q == K_READ || kind_q == K_WRITE)
		? {{(MEM_AW-SEG_W){1'b0}}, s_f} : {{(MEM_AW-SEG_W){1'b0}}, seg_q};
	assign page_addr = e_q + {{(MEM_AW-PAGE_W){1'b0}}, p_f};
	assign mem_raddr = cmd.rd_seg ? seg_addr : page_addr;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = eaddr_q;
		mem_wdata = eval_q;
		priority if (cmd.clr_write) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = (clr_q < MEM_AW'(FRAME_WORDS)) ? '0 : '1;
		end else if (cmd.zero_wr) begin
			mem_we    = 1'b1;
			mem_waddr = zaddr_q;
			mem_wdata = '0;
		end else if (cmd.entry_wr) begin
			mem_we = 1'b1;
		end else begin
			mem_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.rd_seg || cmd.rd_page) rdata_q <= mem[mem_raddr];
	end

	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = mark_q[FIDX_W-1:0];
		bm_wdata = 1'b1;
		priority if (cmd.clr_write) begin
			bm_we    = (clr_q < MEM_AW'(NUM_FRAMES));
			bm_waddr = clr_q[FIDX_W-1:0];
			bm_wdata = (clr_q == '0);
		end else if (cmd.mark_wr) begin
			bm_we = !mark_q[FIDX_W];
		end else begin
			bm_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm[bm_waddr] <= bm_wdata;
		if (cmd.scan_rd) bm_rdata_q <= bm[scan_q];
	end

	assign scan_free = !bm_rdata_q;
	assign found_f   = pair_q ? scan_q - 1'b1 : scan_q;

	sptt_tlb #(.N(TLB_ENTRIES)) u_tlb (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag        (va_q[VA_W-1:FRAME_BITS]),
		.upd_hit    (cmd.tlb_hit_upd),
		.fill       (cmd.tlb_fill),
		.fill_frame (ent_q[MEM_AW-1:FRAME_BITS]),
		.hit        (t_hit),
		.hit_frame  (t_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			tlb_en_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_write) clr_q <= clr_q + 1'b1;
			if (cfg_we) tlb_en_q <= cfg_wdata;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= kind_t'(kind);
			va_q   <= virt_addr;
			seg_q  <= segment;
			pg_q   <= page;
			val_q  <= entry_value;
		end
		if (cmd.seg_latch) e_q <= rdata_q[MEM_AW-1:0];
		if (cmd.ent_latch) ent_q <= rdata_q[MEM_AW-1:0];
		if (cmd.hit_latch) ent_q <= {t_frame, {FRAME_BITS{1'b0}}};
		if (cmd.scan_init) begin
			scan_q      <= '0;
			prev_free_q <= 1'b0;
			pair_q      <= cmd.scan_pair;
		end else if (cmd.scan_next) begin
			scan_q      <= scan_q + 1'b1;
			prev_free_q <= scan_free;
		end
		priority if (cmd.setup_alloc) begin
			zaddr_q    <= {found_f, {FRAME_BITS{1'b0}}};
			zleft_q    <= pair_q ? ZCNT_W'(2 * FRAME_WORDS) : ZCNT_W'(FRAME_WORDS);
			mark_q     <= {1'b0, found_f};
			mark_two_q <= pair_q;
			eaddr_q    <= pair_q ? seg_addr : page_addr;
			eval_q     <= {1'b0, found_f, {FRAME_BITS{1'b0}}};
			if (pair_q) e_q <= {found_f, {FRAME_BITS{1'b0}}};
			else ent_q <= {found_f, {FRAME_BITS{1'b0}}};
		end else if (cmd.setup_load_seg || cmd.setup_load_page) begin
			zaddr_q    <= val_q[MEM_AW-1:0];
			zleft_q    <= cmd.setup_load_seg ? ZCNT_W'(2 * FRAME_WORDS)
				: ZCNT_W'(FRAME_WORDS);
			mark_q     <= {1'b0, val_q[MEM_AW-1:FRAME_BITS]};
			mark_two_q <= cmd.setup_load_seg;
			eaddr_q    <= cmd.setup_load_seg ? seg_addr
				: rdata_q[MEM_AW-1:0] + {{(MEM_AW-PAGE_W){1'b0}}, pg_q};
			eval_q     <= val_q;
		end else begin
			if (cmd.zero_wr) begin
				zaddr_q <= zaddr_q + 1'b1;
				zleft_q <= zleft_q - 1'b1;
			end
			if (cmd.mark_wr && mark_two_q) begin
				mark_q     <= mark_q + 1'b1;
				mark_two_q <= 1'b0;
			end
		end
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			hit_q    <= cmd.res_hit;
			phys_q   <= (cmd.res_status == ST_OK)
				? ent_q + {{(MEM_AW-FRAME_BITS){1'b0}}, w_f} : '0;
		end
	end

	always_comb begin
		sts.clr_done   = &clr_q;
		sts.kind       = kind_q;
		sts.tlb_hit    = tlb_en_q && t_hit;
		sts.tlb_en     = tlb_en_q;
		sts.rd_m1      = &rdata_q;
		sts.rd_zero    = (rdata_q == '0);
		sts.rd_le0     = rdata_q[WORD_W-1] || (rdata_q == '0);
		sts.rd_pos     = !rdata_q[WORD_W-1] && (rdata_q != '0);
		sts.val_pos    = !val_q[WORD_W-1] && (val_q != '0);
		sts.scan_found = scan_free && (!pair_q || prev_free_q);
		sts.scan_last  = (scan_q == FIDX_W'(NUM_FRAMES - 1));
		sts.zero_last  = (zleft_q == ZCNT_W'(1));
		sts.mark_last  = !mark_two_q;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign tlb_hit   = hit_q;
	assign phys_addr = phys_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.zero_wr |-> zleft_q != '0)
		else $error("zeroing past its count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_next |-> !sts.scan_last)
		else $error("frame scan ran past the last frame");

endmodule

// ===== hdl/sptt_ctrl.sv =====
// Controller state machine: sequences clearing, walks, allocation and loads.
module sptt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sptt_pkg::sts_t sts,
	output sptt_pkg::cmd_t cmd
);
	import sptt_pkg::*;

	typedef enum logic [11:0] {
		S_CLEAR    = 12'h001,
		S_IDLE     = 12'h002,
		S_DECODE   = 12'h004,
		S_SEG      = 12'h008,
		S_PG_RD    = 12'h010,
		S_PAGE     = 12'h020,
		S_SRCH_RD  = 12'h040,
		S_SRCH_CHK = 12'h080,
		S_ZERO     = 12'h100,
		S_MARK     = 12'h200,
		S_WRITE    = 12'h400,
		S_FIN      = 12'h800
	} state_t;

	typedef enum logic [1:0] {
		CTX_LOAD       = 2'd0,
		CTX_SEG_ALLOC  = 2'd1,
		CTX_PAGE_ALLOC = 2'd2
	} ctx_t;

	state_t  state_q, state_d;
	ctx_t    ctx_q, ctx_d;
	status_t fin_q, fin_d;
	logic    fin_hit_q, fin_hit_d;
	logic    is_rw;

	assign is_rw = (sts.kind == K_READ) || (sts.kind == K_WRITE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		ctx_d     = ctx_q;
		fin_d     = fin_q;
		fin_hit_d = fin_hit_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.rd_seg = 1'b1;
				priority if (is_rw && sts.tlb_hit) begin
					cmd.tlb_hit_upd = 1'b1;
					cmd.hit_latch   = 1'b1;
					fin_d     = ST_OK;
					fin_hit_d = 1'b1;
					state_d   = S_FIN;
				end else if (sts.kind == K_LOAD_SEG) begin
					cmd.setup_load_seg = 1'b1;
					ctx_d     = CTX_LOAD;
					fin_hit_d = 1'b0;
					state_d   = sts.val_pos ? S_ZERO : S_WRITE;
				end else begin
					state_d = S_SEG;
				end
			end
			S_SEG: begin
				cmd.seg_latch = 1'b1;
				fin_hit_d     = 1'b0;
				priority if (sts.kind == K_LOAD_PAGE) begin
					if (sts.rd_le0) begin
						fin_d   = ST_ERR;
						state_d = S_FIN;
					end else begin
						cmd.setup_load_page = 1'b1;
						ctx_d   = CTX_LOAD;
						state_d = sts.val_pos ? S_ZERO : S_WRITE;
					end
				end else if (sts.rd_m1) begin
					fin_d   = ST_PF;
					state_d = S_FIN;
				end else if (sts.rd_zero && sts.kind == K_WRITE) begin
					cmd.scan_init = 1'b1;
					cmd.scan_pair = 1'b1;
					ctx_d   = CTX_SEG_ALLOC;
					state_d = S_SRCH_RD;
				end else if (sts.rd_le0) begin
					fin_d   = ST_ERR;
					state_d = S_FIN;
				end else begin
					state_d = S_PG_RD;
				end
			end
			S_PG_RD: begin
				cmd.rd_page = 1'b1;
				state_d     = S_PAGE;
			end
			S_PAGE: begin
				fin_hit_d = 1'b0;
				priority if (sts.rd_pos) begin
					cmd.ent_latch = 1'b1;
					fin_d   = ST_OK;
					state_d = S_FIN;
				end else if (sts.rd_m1) begin
					fin_d   = ST_PF;
					state_d = S_FIN;
				end else if (sts.rd_zero && sts.kind == K_WRITE) begin
					cmd.scan_init = 1'b1;
					ctx_d   = CTX_PAGE_ALLOC;
					state_d = S_SRCH_RD;
				end else begin
					fin_d   = ST_ERR;
					state_d = S_FIN;
				end
			end
			S_SRCH_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SRCH_CHK;
			end
			S_SRCH_CHK: begin
				priority if (sts.scan_found) begin
					cmd.setup_alloc = 1'b1;
					state_d = S_ZERO;
				end else if (sts.scan_last) begin
					fin_d   = ST_OOF;
					state_d = S_FIN;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_SRCH_RD;
				end
			end
			S_ZERO: begin
				cmd.zero_wr = 1'b1;
				if (sts.zero_last) state_d = S_MARK;
			end
			S_MARK: begin
				cmd.mark_wr = 1'b1;
				if (sts.mark_last) state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.entry_wr = 1'b1;
				unique case (ctx_q)
					CTX_SEG_ALLOC: state_d = S_PG_RD;
					CTX_PAGE_ALLOC: begin
						fin_d   = ST_OK;
						state_d = S_FIN;
					end
					default: begin
						fin_d   = ST_LOADED;
						state_d = S_FIN;
					end
				endcase
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = fin_q;
					cmd.res_hit    = fin_hit_q;
					cmd.tlb_fill   = (fin_q == ST_OK) && !fin_hit_q && sts.tlb_en;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		ctx_q     <= ctx_d;
		fin_q     <= fin_d;
		fin_hit_q <= fin_hit_d;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== hdl/segmented_paging_translator_tlb_core.sv =====
// Top level of the segmented paging translator with translation buffer.
//
//  channel  direction  handshake              words carried
//  in       input      in_valid / in_stall    kind, virt_addr, segment, page, entry_value
//  out      output     out_valid / out_stall  status, tlb_hit, phys_addr
//  cfg      input      cfg_we                 cfg_wdata (tlb_enable)
//
// After reset a clearing pass writes every memory word, one a cycle, with in_stall
// high. A buffer hit ends without a table walk; a plain walk makes two dependent
// reads on the single memory read port. Allocation adds a bitmap scan of up to 1024
// frames (a read and a check per frame), zeroing of 512 or 1024 words, 1-2 marks and
// one entry write; loads with a positive value add the same zeroing and marks. A held
// result waits in the output register while the next word is taken.
module segmented_paging_translator_tlb_core #(
	parameter int TLB_ENTRIES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [sptt_pkg::VA_W-1:0]         virt_addr,
	input  logic [sptt_pkg::SEG_W-1:0]        segment,
	input  logic [sptt_pkg::PAGE_W-1:0]       page,
	input  logic signed [sptt_pkg::WORD_W-1:0] entry_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic                              tlb_hit,
	output logic [sptt_pkg::MEM_AW-1:0]       phys_addr,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata
);
	import sptt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sptt_dp #(.TLB_ENTRIES(TLB_ENTRIES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.virt_addr   (virt_addr),
		.segment     (segment),
		.page        (page),
		.entry_value (entry_value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.tlb_hit     (tlb_hit),
		.phys_addr   (phys_addr)
	);

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the segmented paging translator: directed, buffer and random tests, frame exhaustion.
`timescale 1ns / 100ps

module tb;
	import sptt_pkg::*;

	typedef struct {
		status_t          st;
		logic             hit;
		logic [MEM_AW-1:0] pa;
	} xlat_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               kind;
	logic [VA_W-1:0]          virt_addr;
	logic [SEG_W-1:0]         segment;
	logic [PAGE_W-1:0]        page;
	logic signed [WORD_W-1:0] entry_value;
	logic                     out_valid;
	logic                     out_stall;
	logic [2:0]               status;
	logic                     tlb_hit;
	logic [MEM_AW-1:0]        phys_addr;
	logic                     cfg_we;
	logic                     cfg_wdata;

	segmented_paging_translator_tlb_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .virt_addr(virt_addr), .segment(segment), .page(page),
		.entry_value(entry_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .tlb_hit(tlb_hit), .phys_addr(phys_addr),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	localparam int NBUF = 4;

	// shadow of the block's state
	logic signed [WORD_W-1:0] shadow_mem [MEM_WORDS];
	bit                       frame_taken [NUM_FRAMES];
	logic [TAG_W-1:0]         buf_tag [NBUF];
	int                       buf_frame [NBUF];
	int                       buf_rank [NBUF];
	bit                       buf_live [NBUF];
	bit                       buf_on;

	xlat_result_t pending_results[$];
	int           mismatches;
	bit           idle_on;
	int           stall_left;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic void clear_words(int base, int n);
		for (int i = 0; i < n; i++)
			shadow_mem[(base + i) % MEM_WORDS] = '0;
	endfunction

	function automatic void take_frame(int f);
		if (f < NUM_FRAMES)
			frame_taken[f] = 1'b1;
	endfunction

	function automatic int free_frame(bit pair);
		for (int f = 0; f < NUM_FRAMES - pair; f++)
			if (!frame_taken[f] && (!pair || !frame_taken[f + 1]))
				return f;
		return -1;
	endfunction

	function automatic status_t walk_tables(int s, int p, bit wr, output int ent);
		int e, pe, pa, f;
		ent = 0;
		e = shadow_mem[s];
		if (e == -1)
			return ST_PF;
		if (e == 0 && wr) begin
			f = free_frame(1'b1);
			if (f < 0)
				return ST_OOF;
			take_frame(f);
			take_frame(f + 1);
			clear_words(f * FRAME_WORDS, 2 * FRAME_WORDS);
			shadow_mem[s] = WORD_W'(f * FRAME_WORDS);
			e = f * FRAME_WORDS;
		end else if (e <= 0) begin
			return ST_ERR;
		end
		pa = (e + p) % MEM_WORDS;
		pe = shadow_mem[pa];
		if (pe > 0) begin
			ent = pe;
			return ST_OK;
		end
		if (pe == -1)
			return ST_PF;
		if (pe == 0 && wr) begin
			f = free_frame(1'b0);
			if (f < 0)
				return ST_OOF;
			take_frame(f);
			clear_words(f * FRAME_WORDS, FRAME_WORDS);
			shadow_mem[pa] = WORD_W'(f * FRAME_WORDS);
			ent = f * FRAME_WORDS;
			return ST_OK;
		end
		return ST_ERR;
	endfunction

	function automatic void fill_buffer(logic [TAG_W-1:0] tag, int frame);
		int slot, floor_rank;
		slot = -1;
		floor_rank = 0;
		for (int i = 0; i < NBUF; i++)
			if (slot < 0 && !buf_live[i])
				slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = NBUF - 1; i >= 0; i--)
				if (buf_rank[i] == 0)
					slot = i;
			floor_rank = buf_rank[slot];
		end
		for (int i = 0; i < NBUF; i++)
			if (i != slot && buf_live[i] && buf_rank[i] > floor_rank)
				buf_rank[i]--;
		buf_live[slot] = 1'b1;
		buf_tag[slot] = tag;
		buf_frame[slot] = frame;
		buf_rank[slot] = NBUF - 1;
	endfunction

	function automatic xlat_result_t translate(kind_t k, logic [VA_W-1:0] va,
			logic [SEG_W-1:0] sg, logic [PAGE_W-1:0] pg, logic signed [WORD_W-1:0] ev);
		xlat_result_t r;
		int val, w, ent, e, r0;
		bit found;
		logic [TAG_W-1:0] tag;
		r.st = ST_LOADED;
		r.hit = 1'b0;
		r.pa = '0;
		val = ev;
		w = va[8:0];
		tag = va[27:9];
		found = 1'b0;
		if (k == K_READ || k == K_WRITE) begin
			if (buf_on)
				for (int i = 0; i < NBUF; i++)
					if (!found && buf_live[i] && buf_tag[i] == tag) begin
						r0 = buf_rank[i];
						for (int j = 0; j < NBUF; j++)
							if (j != i && buf_live[j] && buf_rank[j] > r0)
								buf_rank[j]--;
						buf_rank[i] = NBUF - 1;
						r.st = ST_OK;
						r.hit = 1'b1;
						r.pa = MEM_AW'(buf_frame[i] * FRAME_WORDS + w);
						found = 1'b1;
					end
			if (!found) begin
				r.st = walk_tables(va[27:19], va[18:9], k == K_WRITE, ent);
				if (r.st == ST_OK) begin
					r.pa = MEM_AW'(ent + w);
					if (buf_on)
						fill_buffer(tag, (ent / FRAME_WORDS) % NUM_FRAMES);
				end
			end
		end else if (k == K_LOAD_SEG) begin
			if (val > 0) begin
				clear_words(val, 2 * FRAME_WORDS);
				take_frame(val / FRAME_WORDS);
				take_frame(val / FRAME_WORDS + 1);
			end
			shadow_mem[sg] = ev;
		end else begin
			e = shadow_mem[sg];
			if (e <= 0) begin
				r.st = ST_ERR;
			end else begin
				if (val > 0) begin
					clear_words(val, FRAME_WORDS);
					take_frame(val / FRAME_WORDS);
				end
				shadow_mem[(e + pg) % MEM_WORDS] = ev;
			end
		end
		return r;
	endfunction

	task automatic send_word(kind_t k, logic [VA_W-1:0] va, logic [SEG_W-1:0] sg,
			logic [PAGE_W-1:0] pg, logic signed [WORD_W-1:0] ev);
		in_valid <= 1'b1;
		kind <= k;
		virt_addr <= va;
		segment <= sg;
		page <= pg;
		entry_value <= ev;
		do @(posedge clk); while (in_stall);
		pending_results = {pending_results, translate(k, va, sg, pg, ev)};
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_buffer(bit en);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		buf_on = en;
	endtask

	function automatic logic [VA_W-1:0] vaddr(int s, int p, int w);
		return {SEG_W'(s), PAGE_W'(p), 9'(w)};
	endfunction

	task automatic test_directed;
		send_word(K_READ, '0, '0, '0, '0);
		send_word(K_WRITE, '1, '1, '1, -1);
		send_word(K_READ, '1, '0, '0, '0);
		send_word(K_WRITE, vaddr(1, 2, 7), '0, '0, '0);
		send_word(K_READ, vaddr(1, 2, 511), '0, '0, '0);
		send_word(K_LOAD_SEG, '0, 9'd3, '0, -1);
		send_word(K_READ, vaddr(3, 0, 0), '0, '0, '0);
		send_word(K_WRITE, vaddr(3, 9, 0), '0, '0, '0);
		send_word(K_LOAD_SEG, '0, 9'd4, '0, -7);
		send_word(K_READ, vaddr(4, 0, 0), '0, '0, '0);
		send_word(K_WRITE, vaddr(4, 0, 0), '0, '0, '0);
		send_word(K_LOAD_PAGE, '0, 9'd9, 10'd1, 20'sd1024);
		send_word(K_LOAD_PAGE, '0, 9'd1, 10'd5, -1);
		send_word(K_READ, vaddr(1, 5, 3), '0, '0, '0);
		send_word(K_LOAD_PAGE, '0, 9'd1, 10'd6, '0);
		send_word(K_READ, vaddr(1, 6, 3), '0, '0, '0);
		send_word(K_WRITE, vaddr(1, 6, 3), '0, '0, '0);
		send_word(K_LOAD_PAGE, '0, 9'd1, 10'd7, -3);
		send_word(K_WRITE, vaddr(1, 7, 0), '0, '0, '0);
		// unaligned page base, low bits survive only on the walk
		send_word(K_LOAD_PAGE, '0, 9'd1, 10'd1023, 20'sd40000 + 20'sd5);
		send_word(K_READ, vaddr(1, 1023, 511), '0, '0, '0);
		// largest base wraps the zeroing into frame zero
		send_word(K_LOAD_SEG, '0, 9'd511, '0, 20'sd524287);
		send_word(K_READ, vaddr(511, 1023, 0), '0, '0, '0);
		send_word(K_LOAD_PAGE, '0, 9'd511, '0, 20'sd523776);
	endtask

	task automatic test_buffer;
		set_buffer(1'b1);
		for (int n = 0; n < 24; n++)
			send_word(n % 3 ? K_READ : K_WRITE, vaddr(2, n % 6, $urandom_range(0, 511)),
				'0, '0, '0);
		// stale entry stays after reloading the page entry
		send_word(K_LOAD_PAGE, '0, 9'd2, 10'd0, -1);
		send_word(K_READ, vaddr(2, 0, 1), '0, '0, '0);
		set_buffer(1'b0);
		send_word(K_READ, vaddr(2, 0, 1), '0, '0, '0);
		set_buffer(1'b1);
		send_word(K_READ, vaddr(2, 5, 1), '0, '0, '0);
		send_word(K_READ, vaddr(2, 0, 1), '0, '0, '0);
	endtask

	task automatic random_item;
		int sel, s, p;
		sel = $urandom_range(0, 99);
		s = $urandom_range(0, 7);
		p = $urandom_range(0, 7);
		if (sel < 80)
			send_word(sel < 55 ? K_READ : K_WRITE, vaddr(s, p, $urandom_range(0, 511)),
				'0, '0, '0);
		else if (sel < 87)
			send_word(K_READ, VA_W'($urandom), SEG_W'($urandom), PAGE_W'($urandom),
				WORD_W'($urandom));
		else if (sel < 90)
			send_word(K_WRITE, VA_W'($urandom), '0, '0, '0);
		else if (sel < 95)
			send_word(K_LOAD_PAGE, VA_W'($urandom), SEG_W'(s), PAGE_W'(p),
				$urandom_range(0, 2) == 0 ? WORD_W'($urandom) :
				WORD_W'($urandom_range(0, 2) * FRAME_WORDS - 1));
		else
			send_word(K_LOAD_SEG, VA_W'($urandom),
				$urandom_range(0, 1) ? SEG_W'($urandom) : SEG_W'(s + 8),
				PAGE_W'($urandom), $urandom_range(0, 1) ? WORD_W'($urandom) :
				WORD_W'($urandom_range(0, 1) - 1));
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 5; ph++) begin
			set_buffer(ph % 2 == 0);
			if (ph == 4)
				idle_on = 1'b0;
			repeat (76) random_item();
			if (ph == 1) begin
				// hold off until every word is back
				drain();
			end
		end
	endtask

	task automatic test_exhaustion;
		for (int f = 2; f < NUM_FRAMES; f += 2)
			send_word(K_LOAD_SEG, '0, 9'd500, '0, WORD_W'(f * FRAME_WORDS));
		send_word(K_LOAD_SEG, '0, 9'd499, '0, '0);
		send_word(K_WRITE, vaddr(499, 0, 0), '0, '0, '0);
		send_word(K_WRITE, vaddr(500, 1, 0), '0, '0, '0);
		send_word(K_WRITE, vaddr(500, 2, 0), '0, '0, '0);
		send_word(K_READ, vaddr(500, 2, 0), '0, '0, '0);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		xlat_result_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d hit %0d addr %0h",
						status, tlb_hit, phys_addr);
			end else begin
				x = pending_results.pop_front();
				if (status !== x.st || tlb_hit !== x.hit || phys_addr !== x.pa) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%0h got %0d/%0d/%0h",
							x.st, x.hit, x.pa, status, tlb_hit, phys_addr);
				end
			end
		end
	end

	initial begin
		#300_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		virt_addr = '0;
		segment = '0;
		page = '0;
		entry_value = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		mismatches = 0;
		stall_left = 0;
		idle_on = 1'b1;
		buf_on = 1'b0;
		for (int i = 0; i < MEM_WORDS; i++)
			shadow_mem[i] = i < FRAME_WORDS ? '0 : '1;
		for (int i = 0; i < NUM_FRAMES; i++)
			frame_taken[i] = i == 0;
		for (int i = 0; i < NBUF; i++) begin
			buf_tag[i] = '0;
			buf_frame[i] = 0;
			buf_rank[i] = 0;
			buf_live[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_buffer();
		test_random();
		test_exhaustion();
		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
